// File: rtl/ilst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilst_pkg
// Shared constants, codes and command type for the indexed list store.
// ----------------------------------------------------------------------------
package ilst_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int ACT_W    = 2;
   localparam int POS_W    = 4;
   localparam int STAT_W   = 2;
   localparam int RCNT_W   = 5;

   // Requested actions.
   localparam logic [ACT_W-1:0] ACT_PUSH   = 2'd0;
   localparam logic [ACT_W-1:0] ACT_POP    = 2'd1;
   localparam logic [ACT_W-1:0] ACT_INSERT = 2'd2;
   localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd3;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

   // Datapath operations.
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH   = 3'd1;
   localparam logic [OP_W-1:0] OP_POP    = 3'd2;
   localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [IDX_W-1:0] idx;
   } cmd_type;

endpackage

// File: rtl/ilst_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilst_datapath
// Entry register file with neighbor shifting and a registered read port.
// ----------------------------------------------------------------------------
module ilst_datapath
   import ilst_pkg::*;
(
   input  logic                     clock,
   input  cmd_type                  cmd,
   input  logic signed [DATA_W-1:0] wr_value,
   output logic signed [DATA_W-1:0] rd_value
);

   logic [DATA_W-1:0] entries_ff [CAPACITY];
   logic [DATA_W-1:0] entries_in [CAPACITY];
   logic [DATA_W-1:0] below      [CAPACITY];
   logic [DATA_W-1:0] above      [CAPACITY];
   logic [DATA_W-1:0] rd_ff;
   logic [DATA_W-1:0] rd_in;

   // Each entry sees its lower and upper neighbor; the ends see themselves.
   always_comb begin
      below[0]          = entries_ff[0];
      above[CAPACITY-1] = entries_ff[CAPACITY-1];
      for (int i = 1; i < CAPACITY; i++) begin
         below[i] = entries_ff[i-1];
      end
      for (int i = 0; i < CAPACITY - 1; i++) begin
         above[i] = entries_ff[i+1];
      end
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         entries_in[i] = entries_ff[i];
         unique case (cmd.op)
            OP_PUSH: begin
               if (IDX_W'(i) == cmd.idx) entries_in[i] = wr_value;
            end
            OP_INSERT: begin
               if (IDX_W'(i) == cmd.idx) entries_in[i] = wr_value;
               else if (IDX_W'(i) > cmd.idx) entries_in[i] = below[i];
            end
            OP_REMOVE: begin
               if (IDX_W'(i) >= cmd.idx) entries_in[i] = above[i];
            end
            default: begin
               entries_in[i] = entries_ff[i];
            end
         endcase
      end
   end

   always_comb begin
      if (cmd.op == OP_POP || cmd.op == OP_REMOVE) begin
         rd_in = entries_ff[cmd.idx];
      end else begin
         rd_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         entries_ff[i] <= entries_in[i];
      end
      rd_ff <= rd_in;
   end

   assign rd_value = rd_ff;

endmodule

// File: rtl/ilst_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilst_control
// Length tracking, action checks and result status for the list store.
// ----------------------------------------------------------------------------
module ilst_control
   import ilst_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [ACT_W-1:0]   action,
   input  logic [POS_W-1:0]   position,
   output cmd_type            cmd,
   output logic               rsp_strobe,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [RCNT_W-1:0]  rsp_count
);

   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              strobe_ff;
   logic              strobe_in;
   logic [STAT_W-1:0] status_ff;
   logic [STAT_W-1:0] status_in;
   logic              full;
   logic              in_range;

   assign full     = (count_ff >= CNT_W'(CAPACITY));
   assign in_range = (CMP_W'(position) < CMP_W'(count_ff));

   always_comb begin
      cmd.op    = OP_NONE;
      cmd.idx   = '0;
      status_in = ST_OK;
      count_in  = count_ff;
      if (start) begin
         unique case (action)
            ACT_PUSH: begin
               if (full) begin
                  status_in = ST_FULL;
               end else begin
                  cmd.op   = OP_PUSH;
                  cmd.idx  = IDX_W'(count_ff);
                  count_in = count_ff + CNT_W'(1);
               end
            end
            ACT_POP: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY;
               end else begin
                  cmd.op   = OP_POP;
                  cmd.idx  = IDX_W'(count_ff - CNT_W'(1));
                  count_in = count_ff - CNT_W'(1);
               end
            end
            ACT_INSERT: begin
               // The index is checked before fullness.
               if (!in_range) begin
                  status_in = ST_RANGE;
               end else if (full) begin
                  status_in = ST_FULL;
               end else begin
                  cmd.op   = OP_INSERT;
                  cmd.idx  = IDX_W'(position);
                  count_in = count_ff + CNT_W'(1);
               end
            end
            ACT_REMOVE: begin
               if (!in_range) begin
                  status_in = ST_RANGE;
               end else begin
                  cmd.op   = OP_REMOVE;
                  cmd.idx  = IDX_W'(position);
                  count_in = count_ff - CNT_W'(1);
               end
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end
   end

   assign strobe_in = start;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
      status_ff <= status_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_status = status_ff;
   assign rsp_count  = RCNT_W'(count_ff);

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("list length exceeds capacity");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      start |=> rsp_strobe)
      else $error("accepted item gave no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !start |=> !rsp_strobe)
      else $error("result without an accepted item");

   a_error_keeps_len: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_OK |-> count_ff == $past(count_ff))
      else $error("failed action changed the list length");
`endif

endmodule

// File: rtl/indexed_list_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_store
// Bounded ordered list of signed words with push, pop, insert and remove.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_action, req_position and req_item_value and raise start; the
//   item is taken at the clock edge where start is high and busy is low.
//   busy stays low, so a new item may be presented every cycle.
//   Exactly one result per item appears in the cycle after acceptance, for one
//   cycle, marked by rsp_strobe: rsp_read_value (popped or removed value,
//   zero otherwise), rsp_status and rsp_count (length after the item).
//   Throughput is one item per cycle, set by the update of the entry registers,
//   where the entries above an insert index, or from a remove index upward,
//   load from their neighbor in parallel.
//   A synchronous reset empties the list; stale entry contents are never
//   visible because only entries below the length are read.
//   The receiver cannot stall, so each result must be captured in its cycle.
// ----------------------------------------------------------------------------
module indexed_list_store
   import ilst_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [ACT_W-1:0]         req_action,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_item_value,
   output logic                     rsp_strobe,
   output logic signed [DATA_W-1:0] rsp_read_value,
   output logic [STAT_W-1:0]        rsp_status,
   output logic [RCNT_W-1:0]        rsp_count
);

   cmd_type cmd;

   assign busy = 1'b0;

   ilst_control u_control (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .action     (req_action),
      .position   (req_position),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count)
   );

   ilst_datapath u_datapath (
      .clock    (clock),
      .cmd      (cmd),
      .wr_value (req_item_value),
      .rd_value (rsp_read_value)
   );

endmodule

// File: tb/indexed_list_store_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_store_tb
// Self-checking bench for the indexed list store. A short table of items
// covers empty, full and out-of-range cases and the value extremes. It is
// followed by random push, pop, insert and remove traffic in fill, drain and
// balanced phases. Every result is compared field by field against a typed-in
// expectation or a behavioral copy of the list kept in the bench.
// ----------------------------------------------------------------------------
module indexed_list_store_tb;
   import ilst_pkg::*;

   localparam int RANDOM_ITEMS = 1880;
   localparam int CALM_TAIL    = 200;

   typedef struct packed {
      logic [DATA_W-1:0] read_value;
      logic [STAT_W-1:0] status;
      logic [RCNT_W-1:0] count;
   } list_result_type;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [POS_W-1:0]  position;
      logic [DATA_W-1:0] item_value;
      logic              pinned;
      list_result_type   result;
   } stim_row_type;

   localparam logic [DATA_W-1:0] FILL_VALUES [16] = '{
      32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
      32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0001,
      32'h7FFF_FFFE, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h1234_5678,
      32'hDEAD_BEEF, 32'h0000_FFFF, 32'hFFFF_0000, 32'hC001_D00D
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [ACT_W-1:0]         req_action = ACT_PUSH;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [DATA_W-1:0] req_item_value = '0;
   logic                     rsp_strobe;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic [STAT_W-1:0]        rsp_status;
   logic [RCNT_W-1:0]        rsp_count;

   // Typed-in expectation that travels with the item it belongs to.
   logic                     pin_valid = 1'b0;
   list_result_type          pin_result = '0;

   logic [DATA_W-1:0]        list_image [CAPACITY];
   int                       list_len = 0;
   list_result_type          pending_results [$];
   int                       mismatch_count = 0;
   stim_row_type             dir_rows [$];

   indexed_list_store dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_action     (req_action),
      .req_position   (req_position),
      .req_item_value (req_item_value),
      .rsp_strobe     (rsp_strobe),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #1_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic list_result_type apply_list_op(input logic [ACT_W-1:0] act,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic [DATA_W-1:0] val);
      list_result_type res;
      int              i;
      res.read_value = '0;
      res.status     = ST_OK;
      case (act)
         ACT_PUSH: begin
            if (list_len >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               list_image[list_len] = val;
               list_len++;
            end
         end
         ACT_POP: begin
            if (list_len == 0) begin
               res.status = ST_EMPTY;
            end else begin
               list_len--;
               res.read_value = list_image[list_len];
            end
         end
         ACT_INSERT: begin
            // The index is checked before fullness.
            if (int'(pos) >= list_len) begin
               res.status = ST_RANGE;
            end else if (list_len >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               for (i = list_len; i > int'(pos); i--)
                  list_image[i] = list_image[i - 1];
               list_image[pos] = val;
               list_len++;
            end
         end
         default: begin
            if (int'(pos) >= list_len) begin
               res.status = ST_RANGE;
            end else begin
               res.read_value = list_image[pos];
               for (i = int'(pos); i + 1 < list_len; i++)
                  list_image[i] = list_image[i + 1];
               list_len--;
            end
         end
      endcase
      res.count = RCNT_W'(list_len);
      return res;
   endfunction

   always @(posedge clock) begin : result_monitor
      list_result_type want;
      if (!reset) begin
         if (rsp_strobe !== 1'b0) begin
            if (pending_results.size() == 0) begin
               $error("rsp_strobe with no item outstanding");
               mismatch_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_read_value !== want.read_value) begin
                  $error("rsp_read_value: expected %0d, got %0d",
                         $signed(want.read_value), rsp_read_value);
                  mismatch_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
                  mismatch_count++;
               end
               if (rsp_count !== want.count) begin
                  $error("rsp_count: expected %0d, got %0d", want.count, rsp_count);
                  mismatch_count++;
               end
            end
         end
         if (start && busy === 1'b0) begin
            want = apply_list_op(req_action, req_position, req_item_value);
            if (pin_valid)
               want = pin_result;
            pending_results.push_back(want);
         end
      end
   end

   // Presents one item and returns at the edge that accepts it.
   task automatic send_item(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                            input logic [DATA_W-1:0] val, input logic pinned,
                            input list_result_type pinned_result);
      start          <= 1'b1;
      req_action     <= act;
      req_position   <= pos;
      req_item_value <= val;
      pin_valid      <= pinned;
      pin_result     <= pinned_result;
      @(posedge clock);
      while (busy !== 1'b0)
         @(posedge clock);
   endtask

   initial begin : stimulus
      int               k;
      int               n;
      int               phase_left;
      int               mode;
      int               roll;
      int               burst;
      bit               quiet;
      logic [ACT_W-1:0] act;
      logic [POS_W-1:0] pos;

      dir_rows.push_back('{ACT_POP, 4'd0, 32'd0, 1'b1, {32'd0, ST_EMPTY, 5'd0}});
      dir_rows.push_back('{ACT_REMOVE, 4'd15, 32'd0, 1'b1, {32'd0, ST_RANGE, 5'd0}});
      dir_rows.push_back('{ACT_INSERT, 4'd0, 32'h1234_5678, 1'b1,
                           {32'd0, ST_RANGE, 5'd0}});
      for (k = 0; k < 16; k++)
         dir_rows.push_back('{ACT_PUSH, POS_W'(k), FILL_VALUES[k], 1'b1,
                              {32'd0, ST_OK, RCNT_W'(k + 1)}});
      dir_rows.push_back('{ACT_PUSH, 4'd0, 32'h0BAD_F00D, 1'b1, {32'd0, ST_FULL, 5'd16}});
      dir_rows.push_back('{ACT_INSERT, 4'd15, 32'h0BAD_F00D, 1'b1,
                           {32'd0, ST_FULL, 5'd16}});
      dir_rows.push_back('{ACT_REMOVE, 4'd15, 32'd0, 1'b0, '0});
      dir_rows.push_back('{ACT_INSERT, 4'd0, 32'h8000_0000, 1'b0, '0});
      dir_rows.push_back('{ACT_REMOVE, 4'd0, 32'd0, 1'b0, '0});
      dir_rows.push_back('{ACT_POP, 4'd7, 32'hFFFF_FFFF, 1'b0, '0});

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[r])
         send_item(dir_rows[r].action, dir_rows[r].position, dir_rows[r].item_value,
                   dir_rows[r].pinned, dir_rows[r].result);

      // Fill and drain phases push the list to full and back to empty often.
      phase_left = 0;
      mode       = 0;
      quiet      = 1'b0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (phase_left == 0) begin
            mode       = $urandom_range(0, 2);
            phase_left = $urandom_range(20, 60);
            quiet      = ($urandom_range(0, 3) == 0);
         end
         phase_left--;

         if (n == RANDOM_ITEMS / 2) begin
            start <= 1'b0;
            @(posedge clock);
            while (pending_results.size() != 0)
               @(posedge clock);
         end

         roll = $urandom_range(0, 99);
         case (mode)
            0: act = (roll < 35) ? ACT_PUSH : (roll < 70) ? ACT_INSERT :
                     (roll < 85) ? ACT_POP : ACT_REMOVE;
            1: act = (roll < 15) ? ACT_PUSH : (roll < 30) ? ACT_INSERT :
                     (roll < 65) ? ACT_POP : ACT_REMOVE;
            default: act = ACT_W'($urandom_range(0, 3));
         endcase
         if ($urandom_range(0, 1) == 0)
            pos = POS_W'($urandom_range(0, 15));
         else
            pos = POS_W'($urandom_range(0, 3));
         send_item(act, pos, $urandom, 1'b0, '0);

         if (!quiet && n < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 10);
            start          <= 1'b0;
            req_action     <= ACT_W'($urandom);
            req_position   <= POS_W'($urandom);
            req_item_value <= $urandom;
            repeat (burst) @(posedge clock);
         end
      end

      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);

      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
